/* hw/rtl/led_pattern_mode_sequencer_defines.svh */
// Assertion macros for the LED pattern mode sequencer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LED_PATTERN_MODE_SEQUENCER_DEFINES_SVH
`define LED_PATTERN_MODE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPMS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPMS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lpms_pkg.sv */
// Shared types and constants for the LED pattern mode sequencer.
// No dependencies; imported by every module of the block.
package lpms_pkg;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int REG_W     = 16;
    localparam int PATTERN_W = 32;
    localparam int MODE_W    = 2;
    localparam int DEB_W     = 5;
    localparam int PHASE_W   = 2;
    localparam int BEAT_W    = 3;

    localparam logic [PATTERN_W-1:0] ALL_OFF = '1;
    localparam logic [PATTERN_W-1:0] ALL_ON  = '0;
    localparam logic [REG_W-1:0]     ELAPSED_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_ONE_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_GAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_TWO_ON  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_REST    = 3'd7;

    // Register reset values
    localparam logic [REG_W-1:0] RST_BLINK_PERIOD = 16'd1500;
    localparam logic [REG_W-1:0] RST_CHASE_STEP   = 16'd250;
    localparam logic [REG_W-1:0] RST_FILL_STEP    = 16'd50;
    localparam logic [REG_W-1:0] RST_HOLD_TIME    = 16'd10000;
    localparam logic [REG_W-1:0] RST_BEAT_ONE_ON  = 16'd220;
    localparam logic [REG_W-1:0] RST_BEAT_GAP     = 16'd180;
    localparam logic [REG_W-1:0] RST_BEAT_TWO_ON  = 16'd320;
    localparam logic [REG_W-1:0] RST_BEAT_REST    = 16'd1200;

    // Modes
    localparam logic [MODE_W-1:0] MODE_ALL_ON    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CIRCLE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HEARTBEAT = 2'd3;

    // Circle phases
    localparam logic [PHASE_W-1:0] PH_CHASE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FILL  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_HOLD  = 2'd2;

    // Heartbeat steps
    localparam logic [BEAT_W-1:0] BT_START   = 3'd0;
    localparam logic [BEAT_W-1:0] BT_ONE_ON  = 3'd1;
    localparam logic [BEAT_W-1:0] BT_GAP     = 3'd2;
    localparam logic [BEAT_W-1:0] BT_TWO_ON  = 3'd3;
    localparam logic [BEAT_W-1:0] BT_REST    = 3'd4;

    typedef struct packed {
        logic [REG_W-1:0] blink_period;
        logic [REG_W-1:0] chase_step;
        logic [REG_W-1:0] fill_step;
        logic [REG_W-1:0] hold_time;
        logic [REG_W-1:0] beat_one_on;
        logic [REG_W-1:0] beat_gap;
        logic [REG_W-1:0] beat_two_on;
        logic [REG_W-1:0] beat_rest;
    } cfg_regs_t;

    // Per-tick decision from the mode controller to the animation engine
    typedef struct packed {
        logic              run;    // animation advances this tick
        logic              clear;  // mode advanced: wipe animation state
        logic [MODE_W-1:0] mode;   // mode after this tick
    } lpms_ctl_t;

endpackage

/* hw/rtl/led_pattern_mode_sequencer.sv */
// LED pattern mode sequencer, top level: input beat register, mode control,
// animation engine, config registers and result register. Depends on lpms_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready/s_button_level): one beat per millisecond
//   tick, carrying the raw button level (1 released, 0 pressed).
//   Result channel (m_valid/m_ready/m_*): exactly one beat per input beat, in
//   order, with the 32-bit active-low LED pattern, the frame flag and the mode.
//   Config port (cfg_we/cfg_index/cfg_wdata): write-only, takes effect at the
//   clock edge where cfg_we is high; write only while no tick is in flight.
// Path: an accepted input beat passes two register stages (input register,
//   result register) before it shows as a result beat.
// Throughput: one beat per cycle while m_ready is high; the per-tick update is a
//   single pass of short logic between the input register and the result register.
// Reset: aresetn low at a clock edge restores mode 0, button released, all
//   LEDs off, timers cleared and every config register to its default.
// Stall: when m_ready is low the result register holds; the input register
//   still takes one more beat, then s_ready drops until the result is taken.
module led_pattern_mode_sequencer #(
    parameter int LED_COUNT      = 32,
    parameter int DEBOUNCE_TICKS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beats
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_button_level,
    // result beats
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lpms_pkg::PATTERN_W-1:0] m_led_pattern,
    output logic                           m_frame_update,
    output logic [lpms_pkg::MODE_W-1:0]    m_current_mode,
    // config writes
    input  logic                           cfg_we,
    input  logic [lpms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpms_pkg::REG_W-1:0]     cfg_wdata
);
    import lpms_pkg::*;
    `include "led_pattern_mode_sequencer_defines.svh"

    logic                 in_valid_reg;
    logic                 in_level_reg;
    logic                 m_valid_reg;
    logic [PATTERN_W-1:0] m_pattern_reg;
    logic                 m_frame_reg;
    logic [MODE_W-1:0]    m_mode_reg;

    logic                 tick_en;
    lpms_ctl_t            ctl;
    cfg_regs_t            regs;
    logic [PATTERN_W-1:0] pattern_next;
    logic                 sent;

    // Advance a tick when the input register holds a beat and the result
    // register is free or being drained this cycle.
    assign tick_en = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || tick_en;

    lpms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .regs      (regs)
    );

    lpms_mode_ctrl #(
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_mode_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .button_level (in_level_reg),
        .ctl          (ctl)
    );

    lpms_anim #(
        .LED_COUNT (LED_COUNT)
    ) u_anim (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_en      (tick_en),
        .ctl          (ctl),
        .regs         (regs),
        .pattern_next (pattern_next),
        .sent         (sent)
    );

    // Input register: hold the beat until its tick runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_level_reg <= s_button_level;
        end
    end

    // Result register: load on each tick, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (tick_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_pattern_reg <= pattern_next;
            m_frame_reg   <= sent;
            m_mode_reg    <= ctl.mode;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_led_pattern  = m_pattern_reg;
    assign m_frame_update = m_frame_reg;
    assign m_current_mode = m_mode_reg;

    // A mode change always sends a frame
    `LPMS_ASSERT_NEXT(a_mode_change_sends, aclk, aresetn, tick_en && ctl.clear, m_frame_update, "mode change without frame")
    // Held ticks of the debounce wait send no frame
    `LPMS_ASSERT_NEXT(a_hold_no_frame, aclk, aresetn, tick_en && !ctl.run, !m_frame_update, "frame sent while held")
    // A clear only happens on a tick that runs the animation
    `LPMS_ASSERT_NOW(a_clear_runs, aclk, aresetn, ctl.clear, ctl.run, "clear without run")
    // Both stages full and receiver stalled: no new beat is taken
    `LPMS_ASSERT_NOW(a_full_backpressure, aclk, aresetn, in_valid_reg && m_valid && !m_ready, !s_ready, "beat accepted with pipeline full")

endmodule

/* hw/rtl/lpms_cfg.sv */
// Configuration register file of the LED pattern mode sequencer.
// Depends on lpms_pkg.
module lpms_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [lpms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpms_pkg::REG_W-1:0]     cfg_wdata,
    output lpms_pkg::cfg_regs_t            regs
);
    import lpms_pkg::*;

    cfg_regs_t regs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.blink_period <= RST_BLINK_PERIOD;
            regs_reg.chase_step   <= RST_CHASE_STEP;
            regs_reg.fill_step    <= RST_FILL_STEP;
            regs_reg.hold_time    <= RST_HOLD_TIME;
            regs_reg.beat_one_on  <= RST_BEAT_ONE_ON;
            regs_reg.beat_gap     <= RST_BEAT_GAP;
            regs_reg.beat_two_on  <= RST_BEAT_TWO_ON;
            regs_reg.beat_rest    <= RST_BEAT_REST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BLINK_PERIOD: regs_reg.blink_period <= cfg_wdata;
                REG_CHASE_STEP:   regs_reg.chase_step   <= cfg_wdata;
                REG_FILL_STEP:    regs_reg.fill_step    <= cfg_wdata;
                REG_HOLD_TIME:    regs_reg.hold_time    <= cfg_wdata;
                REG_BEAT_ONE_ON:  regs_reg.beat_one_on  <= cfg_wdata;
                REG_BEAT_GAP:     regs_reg.beat_gap     <= cfg_wdata;
                REG_BEAT_TWO_ON:  regs_reg.beat_two_on  <= cfg_wdata;
                REG_BEAT_REST:    regs_reg.beat_rest    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign regs = regs_reg;

endmodule

/* hw/rtl/lpms_mode_ctrl.sv */
// Button edge detect, debounce wait and mode counter.
// Depends on lpms_pkg.
module lpms_mode_ctrl #(
    parameter int DEBOUNCE_TICKS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                tick_en,
    input  logic                button_level,
    output lpms_pkg::lpms_ctl_t ctl
);
    import lpms_pkg::*;

    localparam logic [DEB_W-1:0] DEB_LIMIT = DEB_W'(DEBOUNCE_TICKS);

    logic              last_button_reg, last_button_next;
    logic [DEB_W-1:0]  deb_count_reg, deb_count_next;
    logic              deb_active_reg, deb_active_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [DEB_W-1:0]  deb_inc;
    logic              run;
    logic              clear;

    assign deb_inc = deb_count_reg + DEB_W'(1);

    always_comb begin
        deb_count_next  = deb_count_reg;
        deb_active_next = deb_active_reg;
        mode_next       = mode_reg;
        last_button_next = button_level;
        run             = 1'b1;
        clear           = 1'b0;
        if (deb_active_reg) begin
            if (deb_inc >= DEB_LIMIT) begin
                deb_active_next = 1'b0;
                deb_count_next  = '0;
                if (!button_level) begin
                    mode_next = mode_reg + MODE_W'(1);
                    clear     = 1'b1;
                end
            end else begin
                deb_count_next = deb_inc;
                run            = 1'b0;
            end
        end else if (last_button_reg && !button_level) begin
            deb_active_next = 1'b1;
            deb_count_next  = '0;
            run             = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_button_reg <= 1'b1;
            deb_count_reg   <= '0;
            deb_active_reg  <= 1'b0;
            mode_reg        <= MODE_ALL_ON;
        end else if (tick_en) begin
            last_button_reg <= last_button_next;
            deb_count_reg   <= deb_count_next;
            deb_active_reg  <= deb_active_next;
            mode_reg        <= mode_next;
        end
    end

    assign ctl.run   = run;
    assign ctl.clear = clear;
    assign ctl.mode  = mode_next;

endmodule

/* hw/rtl/lpms_anim.sv */
// Animation engine: elapsed timer, blink, circle chase/fill/hold and heartbeat.
// Depends on lpms_pkg.
module lpms_anim #(
    parameter int LED_COUNT = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           tick_en,
    input  lpms_pkg::lpms_ctl_t            ctl,
    input  lpms_pkg::cfg_regs_t            regs,
    output logic [lpms_pkg::PATTERN_W-1:0] pattern_next,
    output logic                           sent
);
    import lpms_pkg::*;

    localparam int              IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_START = IDX_W'(LED_COUNT - 1);

    logic [PATTERN_W-1:0] pattern_reg;
    logic                 blink_reg, blink_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [BEAT_W-1:0]    beat_reg, beat_next;
    logic [REG_W-1:0]     elapsed_reg, elapsed_next;

    logic [IDX_W-1:0]     idx_base;
    logic                 idx_on_ring;
    logic [PATTERN_W-1:0] idx_mask;

    // Index the circle step lights: back at the start after a mode change
    assign idx_base    = ctl.clear ? IDX_START : idx_reg;
    // An index past the pattern width lights nothing
    assign idx_on_ring = (int'(idx_base) < PATTERN_W);
    assign idx_mask    = idx_on_ring ? ~(PATTERN_W'(1) << idx_base) : ALL_OFF;

    always_comb begin
        // Base state, wiped on a mode change
        if (ctl.clear) begin
            pattern_next = ALL_OFF;
            blink_next   = 1'b0;
            phase_next   = PH_CHASE;
            idx_next     = IDX_START;
            beat_next    = BT_START;
            elapsed_next = '0;
        end else begin
            pattern_next = pattern_reg;
            blink_next   = blink_reg;
            phase_next   = phase_reg;
            idx_next     = idx_reg;
            beat_next    = beat_reg;
            elapsed_next = elapsed_reg;
        end
        sent = ctl.clear;

        if (ctl.run) begin
            if (!ctl.clear && elapsed_next != ELAPSED_MAX) begin
                elapsed_next = elapsed_next + REG_W'(1);
            end
            case (ctl.mode)
                MODE_ALL_ON: begin
                    pattern_next = ALL_ON;
                    sent         = 1'b1;
                end
                MODE_BLINK: begin
                    if (elapsed_next >= regs.blink_period) begin
                        elapsed_next = '0;
                        blink_next   = ~blink_next;
                        pattern_next = blink_next ? ALL_ON : ALL_OFF;
                        sent         = 1'b1;
                    end
                end
                MODE_CIRCLE: begin
                    unique case (phase_next)
                        PH_CHASE: begin
                            if (elapsed_next >= regs.chase_step) begin
                                elapsed_next = '0;
                                pattern_next = idx_mask;
                                sent         = 1'b1;
                                if (idx_next == '0) begin
                                    idx_next   = IDX_START;
                                    phase_next = PH_FILL;
                                end else begin
                                    idx_next = idx_next - IDX_W'(1);
                                end
                            end
                        end
                        PH_FILL: begin
                            if (elapsed_next >= regs.fill_step) begin
                                elapsed_next = '0;
                                pattern_next = pattern_next & idx_mask;
                                if (idx_on_ring) sent = 1'b1;
                                if (idx_next == '0) begin
                                    phase_next = PH_HOLD;
                                end else begin
                                    idx_next = idx_next - IDX_W'(1);
                                end
                            end
                        end
                        PH_HOLD: begin
                            if (elapsed_next >= regs.hold_time) begin
                                pattern_next = ALL_OFF;
                                sent         = 1'b1;
                                idx_next     = IDX_START;
                                phase_next   = PH_CHASE;
                                elapsed_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: begin
                    unique case (beat_next)
                        BT_START: begin
                            pattern_next = ALL_ON;
                            sent         = 1'b1;
                            elapsed_next = '0;
                            beat_next    = BT_ONE_ON;
                        end
                        BT_ONE_ON: begin
                            if (elapsed_next >= regs.beat_one_on) begin
                                pattern_next = ALL_OFF;
                                sent         = 1'b1;
                                elapsed_next = '0;
                                beat_next    = BT_GAP;
                            end
                        end
                        BT_GAP: begin
                            if (elapsed_next >= regs.beat_gap) begin
                                pattern_next = ALL_ON;
                                sent         = 1'b1;
                                elapsed_next = '0;
                                beat_next    = BT_TWO_ON;
                            end
                        end
                        BT_TWO_ON: begin
                            if (elapsed_next >= regs.beat_two_on) begin
                                pattern_next = ALL_OFF;
                                sent         = 1'b1;
                                elapsed_next = '0;
                                beat_next    = BT_REST;
                            end
                        end
                        BT_REST: begin
                            if (elapsed_next >= regs.beat_rest) beat_next = BT_START;
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= ALL_OFF;
            blink_reg   <= 1'b0;
            phase_reg   <= PH_CHASE;
            idx_reg     <= IDX_START;
            beat_reg    <= BT_START;
            elapsed_reg <= '0;
        end else if (tick_en) begin
            pattern_reg <= pattern_next;
            blink_reg   <= blink_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            beat_reg    <= beat_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

/* dv/led_frame_monitor.sv */
// Monitor and scoreboard for the LED pattern mode sequencer: follows the tick,
// result and register-write ports, predicts each result beat and compares it.
// Depends on lpms_pkg.
`timescale 1ns / 1ps

module led_frame_monitor #(
    parameter int LED_COUNT      = 32,
    parameter int DEBOUNCE_TICKS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_button_level,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [lpms_pkg::PATTERN_W-1:0] m_led_pattern,
    input  logic                           m_frame_update,
    input  logic [lpms_pkg::MODE_W-1:0]    m_current_mode,
    input  logic                           cfg_we,
    input  logic [lpms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lpms_pkg::REG_W-1:0]     cfg_wdata,
    output int unsigned                    error_count,
    output int unsigned                    pending_count,
    output int unsigned                    checked_count,
    output int unsigned                    frame_count,
    output int unsigned                    advance_count
);
    import lpms_pkg::*;

    localparam logic [5:0] LAST_LED = 6'((LED_COUNT - 1) & 'h3F);

    typedef struct packed {
        logic [PATTERN_W-1:0] pattern;
        logic                 frame;
        logic [MODE_W-1:0]    mode;
    } led_frame_t;

    led_frame_t pending_frames[$];

    // Predicted state of the block
    cfg_regs_t            regs;
    logic [MODE_W-1:0]    mode_q;
    logic                 btn_prev;
    logic [DEB_W-1:0]     deb_cnt;
    logic                 deb_busy;
    logic [REG_W-1:0]     elapsed;
    logic                 blink_lit;
    logic [PHASE_W-1:0]   ring_phase;
    logic [5:0]           led_idx;
    logic [BEAT_W-1:0]    beat_q;
    logic [PATTERN_W-1:0] pattern_q;

    function automatic void clear_animation();
        pattern_q  = ALL_OFF;
        blink_lit  = 1'b0;
        ring_phase = PH_CHASE;
        led_idx    = LAST_LED;
        beat_q     = BT_START;
        elapsed    = '0;
    endfunction

    function automatic void reset_model();
        regs.blink_period = RST_BLINK_PERIOD;
        regs.chase_step   = RST_CHASE_STEP;
        regs.fill_step    = RST_FILL_STEP;
        regs.hold_time    = RST_HOLD_TIME;
        regs.beat_one_on  = RST_BEAT_ONE_ON;
        regs.beat_gap     = RST_BEAT_GAP;
        regs.beat_two_on  = RST_BEAT_TWO_ON;
        regs.beat_rest    = RST_BEAT_REST;
        mode_q   = MODE_ALL_ON;
        btn_prev = 1'b1;
        deb_cnt  = '0;
        deb_busy = 1'b0;
        clear_animation();
    endfunction

    // Indexes past the ring are simply dropped
    function automatic bit light_led(input logic [5:0] idx);
        if (idx >= 32) return 1'b0;
        pattern_q[idx[4:0]] = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit step_circle();
        bit sent;
        sent = 1'b0;
        case (ring_phase)
            PH_CHASE: if (elapsed >= regs.chase_step) begin
                elapsed   = '0;
                pattern_q = ALL_OFF;
                sent      = 1'b1;
                void'(light_led(led_idx));
                if (led_idx == 0) begin
                    led_idx    = LAST_LED;
                    ring_phase = PH_FILL;
                end else begin
                    led_idx = led_idx - 6'd1;
                end
            end
            PH_FILL: if (elapsed >= regs.fill_step) begin
                elapsed = '0;
                sent    = light_led(led_idx);
                if (led_idx == 0) ring_phase = PH_HOLD;
                else led_idx = led_idx - 6'd1;
            end
            PH_HOLD: if (elapsed >= regs.hold_time) begin
                pattern_q  = ALL_OFF;
                sent       = 1'b1;
                led_idx    = LAST_LED;
                ring_phase = PH_CHASE;
                elapsed    = '0;
            end
            default: ;
        endcase
        return sent;
    endfunction

    function automatic bit step_heartbeat();
        bit sent;
        sent = 1'b0;
        case (beat_q)
            BT_START: begin
                pattern_q = ALL_ON;
                sent      = 1'b1;
                elapsed   = '0;
                beat_q    = BT_ONE_ON;
            end
            BT_ONE_ON: if (elapsed >= regs.beat_one_on) begin
                pattern_q = ALL_OFF;
                sent      = 1'b1;
                elapsed   = '0;
                beat_q    = BT_GAP;
            end
            BT_GAP: if (elapsed >= regs.beat_gap) begin
                pattern_q = ALL_ON;
                sent      = 1'b1;
                elapsed   = '0;
                beat_q    = BT_TWO_ON;
            end
            BT_TWO_ON: if (elapsed >= regs.beat_two_on) begin
                pattern_q = ALL_OFF;
                sent      = 1'b1;
                elapsed   = '0;
                beat_q    = BT_REST;
            end
            BT_REST: if (elapsed >= regs.beat_rest) beat_q = BT_START;
            default: ;
        endcase
        return sent;
    endfunction

    // One millisecond tick: debounce, then the animation of the current mode
    function automatic led_frame_t advance_tick(input logic level);
        led_frame_t res;
        bit run;
        bit changed;
        bit sent;
        run     = 1'b1;
        changed = 1'b0;
        sent    = 1'b0;
        if (deb_busy) begin
            deb_cnt = deb_cnt + 1'b1;
            if (deb_cnt >= DEBOUNCE_TICKS) begin
                deb_busy = 1'b0;
                deb_cnt  = '0;
                if (!level) begin
                    mode_q = mode_q + 2'd1;
                    clear_animation();
                    sent    = 1'b1;
                    changed = 1'b1;
                    advance_count++;
                end
            end else begin
                run = 1'b0;
            end
        end else if (btn_prev && !level) begin
            deb_busy = 1'b1;
            deb_cnt  = '0;
            run      = 1'b0;
        end
        btn_prev = level;

        if (run) begin
            if (!changed && elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
            case (mode_q)
                MODE_ALL_ON: begin
                    pattern_q = ALL_ON;
                    sent      = 1'b1;
                end
                MODE_BLINK: if (elapsed >= regs.blink_period) begin
                    elapsed   = '0;
                    blink_lit = !blink_lit;
                    pattern_q = blink_lit ? ALL_ON : ALL_OFF;
                    sent      = 1'b1;
                end
                MODE_CIRCLE: if (step_circle()) sent = 1'b1;
                default: if (step_heartbeat()) sent = 1'b1;
            endcase
        end

        res.pattern = pattern_q;
        res.frame   = sent;
        res.mode    = mode_q;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch at result beat %0d: %s got 0x%08h want 0x%08h",
                 $time, checked_count, what, got, want);
    endtask

    always @(posedge aclk) begin
        led_frame_t want;
        if (!aresetn) begin
            reset_model();
            pending_frames.delete();
        end else begin
            if (m_valid && m_ready) begin
                checked_count++;
                if (pending_frames.size() == 0) begin
                    report_mismatch("beat with nothing pending", m_led_pattern, '0);
                end else begin
                    want = pending_frames.pop_front();
                    if (want.frame) frame_count++;
                    if (m_led_pattern !== want.pattern)
                        report_mismatch("led_pattern", m_led_pattern, want.pattern);
                    if (m_frame_update !== want.frame)
                        report_mismatch("frame_update", 32'(m_frame_update), 32'(want.frame));
                    if (m_current_mode !== want.mode)
                        report_mismatch("current_mode", 32'(m_current_mode), 32'(want.mode));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BLINK_PERIOD: regs.blink_period = cfg_wdata;
                    REG_CHASE_STEP:   regs.chase_step   = cfg_wdata;
                    REG_FILL_STEP:    regs.fill_step    = cfg_wdata;
                    REG_HOLD_TIME:    regs.hold_time    = cfg_wdata;
                    REG_BEAT_ONE_ON:  regs.beat_one_on  = cfg_wdata;
                    REG_BEAT_GAP:     regs.beat_gap     = cfg_wdata;
                    REG_BEAT_TWO_ON:  regs.beat_two_on  = cfg_wdata;
                    default:          regs.beat_rest    = cfg_wdata;
                endcase
            end
            if (s_valid && s_ready)
                pending_frames.push_back(advance_tick(s_button_level));
        end
        pending_count = pending_frames.size();
    end

endmodule

/* dv/tb_top.sv */
// Top of the LED pattern mode sequencer testbench: clock, reset, tick and
// register-write stimulus, result-side backpressure and the verdict.
// Depends on lpms_pkg, led_pattern_mode_sequencer and led_frame_monitor.
`timescale 1ns / 1ps

module tb_top;
    import lpms_pkg::*;

    localparam int          CLK_PERIOD     = 20;
    localparam int          LED_COUNT      = 32;
    localparam int          DEBOUNCE_TICKS = 20;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES   = 4;
    localparam logic [REG_W-1:0] REG_MAX   = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_button_level;
    logic                 m_valid;
    logic                 m_ready;
    logic [PATTERN_W-1:0] m_led_pattern;
    logic                 m_frame_update;
    logic [MODE_W-1:0]    m_current_mode;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;

    int unsigned       error_count;
    int unsigned       pending_count;
    int unsigned       checked_count;
    int unsigned       frame_count;
    int unsigned       advance_count;

    // Shared between the tick sender and the result receiver
    bit          quiet;        // both sides run without idle cycles
    int unsigned rx_hold_req;  // one-shot long stall for the receiver
    int unsigned ticks_sent;
    int unsigned cycle_count;
    int unsigned settings_used;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    led_pattern_mode_sequencer #(
        .LED_COUNT      (LED_COUNT),
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_pattern  (m_led_pattern),
        .m_frame_update (m_frame_update),
        .m_current_mode (m_current_mode),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    led_frame_monitor #(
        .LED_COUNT      (LED_COUNT),
        .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
    ) u_frame_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_pattern  (m_led_pattern),
        .m_frame_update (m_frame_update),
        .m_current_mode (m_current_mode),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .frame_count    (frame_count),
        .advance_count  (advance_count)
    );

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: stall for a random gap before each beat unless quiet is set, or hold
    // off for a long stretch when asked, so the block backs up into s_ready.
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req != 0) begin
                stall       = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 7);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one tick beat after a random idle gap; return at the edge where
    // it is taken. Valid stays high across back-to-back beats.
    task automatic send_tick(input logic level);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_level <= level;
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    task automatic release_run(input int unsigned n);
        repeat (n) send_tick(1'b1);
    endtask

    task automatic hold_low(input int unsigned n);
        repeat (n) send_tick(1'b0);
    endtask

    // Falling edge, the debounce wait (optionally bouncing), then the
    // decision tick: low advances the mode, high rejects the press.
    task automatic press(input bit accept, input bit bounce);
        send_tick(1'b0);
        repeat (DEBOUNCE_TICKS - 1) send_tick(bounce ? ($urandom_range(0, 1) == 1) : 1'b0);
        send_tick(!accept);
    endtask

    // Drop valid, let every predicted result drain, then allow the block's
    // two-stage latency before anything touches the registers.
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input logic [REG_W-1:0] blink, chase, fill, hold,
                                input logic [REG_W-1:0] one_on, gap, two_on, rest);
        write_reg(REG_BLINK_PERIOD, blink);
        write_reg(REG_CHASE_STEP,   chase);
        write_reg(REG_FILL_STEP,    fill);
        write_reg(REG_HOLD_TIME,    hold);
        write_reg(REG_BEAT_ONE_ON,  one_on);
        write_reg(REG_BEAT_GAP,     gap);
        write_reg(REG_BEAT_TWO_ON,  two_on);
        write_reg(REG_BEAT_REST,    rest);
        settings_used++;
    endtask

    // Short periods keep every animation moving within a few hundred ticks
    function automatic logic [REG_W-1:0] short_period();
        return REG_W'($urandom_range(0, 6));
    endfunction

    // Mostly well-formed press sequences and release runs with random
    // lengths, plus some noise; optionally one long receiver hold-off.
    task automatic random_phase(input int unsigned n, input bit hold_off);
        int unsigned start;
        int unsigned pick;
        start = ticks_sent;
        while (ticks_sent - start < n) begin
            quiet = ($urandom_range(0, 4) == 0);
            if (hold_off && ticks_sent - start >= n / 3) begin
                quiet       = 1'b0;
                rx_hold_req = RX_HOLD_CYCLES;
                hold_off    = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                release_run(($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                       : $urandom_range(1, 40));
            end else if (pick < 85) begin
                press($urandom_range(0, 4) != 0, $urandom_range(0, 1) == 1);
                hold_low($urandom_range(0, 5));
            end else begin
                repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1) == 1);
            end
        end
        quiet = 1'b0;
        quiesce();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_button_level = 1'b1;
        cfg_we         = 1'b0;
        cfg_index      = REG_BLINK_PERIOD;
        cfg_wdata      = '0;
        quiet          = 1'b0;
        rx_hold_req    = 0;
        ticks_sent     = 0;
        cycle_count    = 0;
        settings_used  = 1;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, reset values: all-on frames, then a press that bounces
        // through its debounce wait (the bounces must not restart it) and
        // is still low on the decision tick, so the mode moves to blink.
        release_run(2);
        send_tick(1'b0);
        for (int i = 0; i < DEBOUNCE_TICKS - 1; i++) send_tick(i[0]);
        send_tick(1'b0);
        release_run(2);
        quiesce();

        // Periods of one: every animation cycles quickly; the first release run has no idling
        program_regs(1, 1, 1, 1, 1, 1, 1, 1);
        quiet = 1'b1;
        release_run(4);
        random_phase(150, 1'b0);

        // Zero periods: every compare holds, steps fire on each tick
        program_regs(0, 0, 0, 0, 0, 0, 0, 0);
        random_phase(100, 1'b0);

        // Mixed short periods, two phases with a long receiver hold-off
        repeat (4) begin
            program_regs(short_period(), short_period(), short_period(), short_period(),
                         short_period(), short_period(), short_period(), short_period());
            random_phase(110, settings_used % 2 == 1);
        end

        // Wide random blink, hold, beat-one-on and beat-two-on values; short chase, fill, gap and rest
        program_regs(REG_W'($urandom()), short_period(), short_period(), REG_W'($urandom()),
                     REG_W'($urandom()), short_period(), REG_W'($urandom()), short_period());
        random_phase(60, 1'b0);

        // Longest periods: no timed step fires; frames come only from mode changes, all-on and the heartbeat start
        program_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        random_phase(80, 1'b0);

        $display("Covered %0d ticks under %0d register settings: %0d results checked,",
                 ticks_sent, settings_used, checked_count);
        $display("%0d frames sent and %0d mode advances, %0d mismatches.",
                 frame_count, advance_count, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
